// File: hw/rtl/fpalu_pkg.sv
// Package with the opcodes, widths and shared types of the fixed-point ALU.
package fpalu_pkg;

	localparam int FracBits  = 8;
	localparam int DataW     = 32;
	localparam int ProdW     = 2 * DataW;
	localparam int NumW      = DataW + FracBits + 1;
	localparam int DivSteps  = DataW + FracBits;
	localparam int InTdataW  = 72;
	localparam int OutTdataW = 32;

	typedef enum logic [3:0] {
		OP_ADD     = 4'd0,
		OP_SUB     = 4'd1,
		OP_MUL     = 4'd2,
		OP_DIV     = 4'd3,
		OP_GT      = 4'd4,
		OP_LT      = 4'd5,
		OP_GE      = 4'd6,
		OP_LE      = 4'd7,
		OP_EQ      = 4'd8,
		OP_NE      = 4'd9,
		OP_MIN     = 4'd10,
		OP_MAX     = 4'd11,
		OP_INC     = 4'd12,
		OP_DEC     = 4'd13,
		OP_TOINT   = 4'd14,
		OP_FROMINT = 4'd15
	} op_t;

	// Class decided by the front part.
	typedef enum logic [1:0] {
		CLS_SIMPLE = 2'd0,
		CLS_MUL    = 2'd1,
		CLS_DIV    = 2'd2
	} cls_t;

	// Item as it sits in the queue between front and back.
	typedef struct packed {
		cls_t                     cls;
		logic [DataW-1:0]         simple_value;
		logic                     simple_cmp;
		logic                     div_zero;
		logic signed [DataW-1:0]  a;
		logic signed [DataW-1:0]  b;
	} item_t;

	typedef struct packed {
		logic [DataW-1:0] value;
		logic             cmp;
		logic             dz;
	} res_t;

endpackage

// File: hw/rtl/fpalu_front.sv
// Front part: decodes the opcode and works out, combinationally, all operations but multiply and divide.
module fpalu_front (
	input  logic [3:0]                      func,
	input  logic signed [fpalu_pkg::DataW-1:0] operand_a,
	input  logic signed [fpalu_pkg::DataW-1:0] operand_b,
	output fpalu_pkg::item_t                item
);
	logic a_lt_b;
	logic b_lt_a;
	logic [fpalu_pkg::DataW-1:0] val;
	logic cmp;
	fpalu_pkg::cls_t cls;

	assign a_lt_b = operand_a < operand_b;
	assign b_lt_a = operand_b < operand_a;

	// Opcode decode and simple results.
	always_comb begin
		val = '0;
		cmp = 1'b0;
		cls = fpalu_pkg::CLS_SIMPLE;
		unique case (fpalu_pkg::op_t'(func))
			fpalu_pkg::OP_ADD:     val = operand_a + operand_b;
			fpalu_pkg::OP_SUB:     val = operand_a - operand_b;
			fpalu_pkg::OP_MUL:     cls = fpalu_pkg::CLS_MUL;
			fpalu_pkg::OP_DIV:     cls = fpalu_pkg::CLS_DIV;
			fpalu_pkg::OP_GT:      cmp = b_lt_a;
			fpalu_pkg::OP_LT:      cmp = a_lt_b;
			fpalu_pkg::OP_GE:      cmp = !a_lt_b;
			fpalu_pkg::OP_LE:      cmp = !b_lt_a;
			fpalu_pkg::OP_EQ:      cmp = operand_a == operand_b;
			fpalu_pkg::OP_NE:      cmp = operand_a != operand_b;
			fpalu_pkg::OP_MIN:     val = a_lt_b ? operand_a : operand_b;
			fpalu_pkg::OP_MAX:     val = b_lt_a ? operand_a : operand_b;
			fpalu_pkg::OP_INC:     val = operand_a + 32'sd1;
			fpalu_pkg::OP_DEC:     val = operand_a - 32'sd1;
			fpalu_pkg::OP_TOINT:   val = operand_a >>> fpalu_pkg::FracBits;
			fpalu_pkg::OP_FROMINT: val = operand_a << fpalu_pkg::FracBits;
			default:               val = '0;
		endcase
	end

	assign item.cls          = cls;
	assign item.simple_value = val;
	assign item.simple_cmp   = cmp;
	assign item.div_zero     = (cls == fpalu_pkg::CLS_DIV) && (operand_b == '0);
	assign item.a            = operand_a;
	assign item.b            = operand_b;
endmodule

// File: hw/rtl/fpalu_queue.sv
// Two-entry queue between the front and back parts.
module fpalu_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  fpalu_pkg::item_t wr_item,
	output logic             rd_valid,
	input  logic             rd_ready,
	output fpalu_pkg::item_t rd_item
);
	fpalu_pkg::item_t mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign wr_ready = count_q != 2'd2;
	assign rd_valid = count_q != 2'd0;
	assign rd_item  = mem_q[rptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wptr_q <= !wptr_q;
			if (pop) rptr_q <= !rptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// File: hw/rtl/fpalu_back.sv
// Back part: pipelined multiplier and radix-2 divider, one stage per quotient bit.
module fpalu_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  fpalu_pkg::item_t in_item,
	output logic             out_valid,
	input  logic             out_ready,
	output fpalu_pkg::res_t  out_res
);
	localparam int N  = fpalu_pkg::DivSteps;
	localparam int W  = fpalu_pkg::DataW;
	localparam int NW = fpalu_pkg::NumW;

	// Pipeline state: one slot per stage, plus an output register.
	logic                 vld_q  [N+1];
	fpalu_pkg::item_t     itm_q  [N+1];
	logic [NW-1:0]        rem_q  [N+1];
	logic [N-1:0]         quo_q  [N+1];
	logic [NW-1:0]        nmag_q [N+1];
	logic [W-1:0]         dmag_q [N+1];
	logic                 neg_q  [N+1];
	logic signed [2*W-1:0] prod_q;
	logic                 adv;
	logic                 out_vld_q;
	fpalu_pkg::res_t      out_res_q;

	logic [NW-1:0] num_in;
	logic [NW-1:0] nmag_in;
	logic [W-1:0]  dmag_in;

	// Whole pipe advances when the output slot is free or being taken.
	assign adv      = !out_vld_q || out_ready;
	assign in_ready = adv;

	assign num_in  = NW'(in_item.a) << fpalu_pkg::FracBits;
	assign nmag_in = in_item.a[W-1] ? (NW'(0) - {{(NW-W){in_item.a[W-1]}}, in_item.a}
		<< fpalu_pkg::FracBits) : num_in;
	assign dmag_in = in_item.b[W-1] ? (W'(0) - in_item.b) : in_item.b;

	// Entry stage and restoring division stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= N; i++) vld_q[i] <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= in_valid;
			for (int i = 1; i <= N; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			itm_q[0]  <= in_item;
			rem_q[0]  <= '0;
			quo_q[0]  <= '0;
			nmag_q[0] <= nmag_in;
			dmag_q[0] <= dmag_in;
			neg_q[0]  <= in_item.a[W-1] ^ in_item.b[W-1];
			prod_q    <= in_item.a * in_item.b;
			for (int i = 1; i <= N; i++) begin
				logic [NW:0] trial;
				logic [NW-1:0] sh;
				logic [N-1:0] qn;
				sh = {rem_q[i-1][NW-2:0], nmag_q[i-1][N-i]};
				trial = {1'b0, sh} - {{(NW+1-W){1'b0}}, dmag_q[i-1]};
				qn = quo_q[i-1];
				qn[N-i] = !trial[NW];
				itm_q[i]  <= itm_q[i-1];
				nmag_q[i] <= nmag_q[i-1];
				dmag_q[i] <= dmag_q[i-1];
				neg_q[i]  <= neg_q[i-1];
				quo_q[i]  <= qn;
				rem_q[i]  <= trial[NW] ? sh : trial[NW-1:0];
			end
		end
	end

	// Multiplier product rides along in a delay line to match the divider depth.
	logic signed [2*W-1:0] prod_d_q [N];
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_d_q[0] <= prod_q;
			for (int i = 1; i < N; i++) prod_d_q[i] <= prod_d_q[i-1];
		end
	end

	// Result selection into the output register.
	fpalu_pkg::res_t res_next;
	logic [W-1:0]    q32;
	logic signed [2*W-1:0] pshift;
	assign q32    = quo_q[N][W-1:0];
	assign pshift = prod_d_q[N-1] >>> fpalu_pkg::FracBits;
	always_comb begin
		res_next = '0;
		case (itm_q[N].cls)
			fpalu_pkg::CLS_MUL: res_next.value = pshift[W-1:0];
			fpalu_pkg::CLS_DIV: begin
				res_next.dz    = itm_q[N].div_zero;
				res_next.value = itm_q[N].div_zero ? '0 : (neg_q[N] ? W'(0) - q32 : q32);
			end
			default: begin
				res_next.value = itm_q[N].simple_value;
				res_next.cmp   = itm_q[N].simple_cmp;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_q[N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) out_res_q <= res_next;
	end

	assign out_valid = out_vld_q;
	assign out_res   = out_res_q;
endmodule

// File: hw/rtl/fixed_point_alu.sv
// Top level of the fixed-point ALU: front decode, queue, pipelined back part.
//
// Channel | Direction | Payload
// s_axis  | in        | func, operand_a, operand_b
// m_axis  | out       | result_value, compare_true, divide_by_zero
//
// One item a cycle is taken and one result a cycle given when the output flows.
// An item passes through the queue, which is written at the accepting edge, then one entry stage,
// one stage per quotient bit of the divider (40), and the output register.
// Reset empties the queue and the pipeline; there is no clearing pass.
// A stall at the output freezes the whole back pipe; the queue fills, then input stalls.
module fixed_point_alu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// func [3:0], operand_a [35:4], operand_b [67:36], zero [71:68]
	input  logic [fpalu_pkg::InTdataW-1:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// result_value [31:0]
	output logic [fpalu_pkg::OutTdataW-1:0] m_axis_tdata,
	// compare_true [0], divide_by_zero [1]
	output logic [1:0]  m_axis_tuser
);
	fpalu_pkg::item_t f_item;
	fpalu_pkg::item_t q_item;
	fpalu_pkg::res_t  res;
	logic q_valid;
	logic q_ready;

	// Front decode.
	fpalu_front u_front (
		.func      (s_axis_tdata[3:0]),
		.operand_a (s_axis_tdata[35:4]),
		.operand_b (s_axis_tdata[67:36]),
		.item      (f_item)
	);

	// Decoupling queue.
	fpalu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (s_axis_tvalid),
		.wr_ready (s_axis_tready),
		.wr_item  (f_item),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_item  (q_item)
	);

	// Back execution.
	fpalu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_ready  (q_ready),
		.in_item   (q_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = res.value;
	assign m_axis_tuser = {res.dz, res.cmp};

`ifndef SYNTHESIS
	// A divide-by-zero result always carries a zero value.
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == '0)
		else $error("divide by zero with non-zero result");
	// Compare flag and divide flag never both set.
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("compare and divide flags both set");
	// An output stall holds the back pipe, so the queue cannot pop.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !q_ready)
		else $error("back part advanced under output stall");
`endif
endmodule

// File: tb/tb_fixed_point_alu.sv
// Testbench for the fixed-point ALU: directed and random operations checked against a predictor.
module tb_fixed_point_alu;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit = 400000;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [fpalu_pkg::InTdataW-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [fpalu_pkg::OutTdataW-1:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;

	typedef struct {
		logic [31:0] value;
		logic        cmp;
		logic        dz;
	} alu_res_t;

	alu_res_t pending_results[$];
	int       mismatches = 0;
	int       cycles = 0;
	int       burst_left;

	fixed_point_alu dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Signed less-than on raw 32-bit values.
	function automatic logic lt_s(logic [31:0] x, logic [31:0] y);
		return $signed(x) < $signed(y);
	endfunction

	// Works out the result the ALU should give for one operation.
	function automatic alu_res_t alu_predict(fpalu_pkg::op_t op, logic [31:0] a,
			logic [31:0] b);
		alu_res_t r;
		logic signed [63:0] prod;
		logic signed [63:0] num;
		logic signed [63:0] quo;
		r = '{value: '0, cmp: 1'b0, dz: 1'b0};
		case (op)
			fpalu_pkg::OP_ADD: r.value = a + b;
			fpalu_pkg::OP_SUB: r.value = a - b;
			fpalu_pkg::OP_MUL: begin
				prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
				prod = prod >>> fpalu_pkg::FracBits;
				r.value = prod[31:0];
			end
			fpalu_pkg::OP_DIV: begin
				if (b == 0) begin
					r.dz = 1'b1;
				end else begin
					// Verilog signed division truncates toward zero.
					num = $signed({{32{a[31]}}, a}) <<< fpalu_pkg::FracBits;
					quo = num / $signed({{32{b[31]}}, b});
					r.value = quo[31:0];
				end
			end
			fpalu_pkg::OP_GT: r.cmp = lt_s(b, a);
			fpalu_pkg::OP_LT: r.cmp = lt_s(a, b);
			fpalu_pkg::OP_GE: r.cmp = !lt_s(a, b);
			fpalu_pkg::OP_LE: r.cmp = !lt_s(b, a);
			fpalu_pkg::OP_EQ: r.cmp = a == b;
			fpalu_pkg::OP_NE: r.cmp = a != b;
			fpalu_pkg::OP_MIN: r.value = lt_s(a, b) ? a : b;
			fpalu_pkg::OP_MAX: r.value = lt_s(b, a) ? a : b;
			fpalu_pkg::OP_INC: r.value = a + 1;
			fpalu_pkg::OP_DEC: r.value = a - 1;
			fpalu_pkg::OP_TOINT: r.value = $signed(a) >>> fpalu_pkg::FracBits;
			default: r.value = a << fpalu_pkg::FracBits;
		endcase
		return r;
	endfunction

	// Sends one operation, waiting out random gaps between bursts.
	task automatic send_op(fpalu_pkg::op_t op, logic [31:0] a, logic [31:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 3) * ($urandom_range(0, 2) == 0);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'b0, b, a, op};
		pending_results.push_back(alu_predict(op, a, b));
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic idle_input();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// Random operand, weighted towards interesting values.
	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(0, 1) ? 32'h0 : 32'hffff_ffff;
			3: return $signed($urandom_range(0, 2000)) - 1000;
			4: return ($signed($urandom_range(0, 200)) - 100) <<< fpalu_pkg::FracBits;
			default: return $urandom;
		endcase
	endfunction

	// Every operation once on extreme operand values, plus zero divisor, ties and other corner cases.
	task automatic test_directed();
		logic [31:0] vals[5];
		vals = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h0000_0100};
		for (int op = 0; op < 16; op++) begin
			send_op(fpalu_pkg::op_t'(op), vals[op % 5], vals[(op + 2) % 5]);
		end
		send_op(fpalu_pkg::OP_DIV, 32'h0000_0500, 32'h0);
		send_op(fpalu_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ffff);
		send_op(fpalu_pkg::OP_DIV, 32'hffff_fd00, 32'h0000_0200);
		send_op(fpalu_pkg::OP_MIN, 32'h1234, 32'h1234);
		send_op(fpalu_pkg::OP_MAX, 32'h8000_0000, 32'h8000_0000);
		send_op(fpalu_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000);
		send_op(fpalu_pkg::OP_TOINT, 32'hffff_ff01, 32'h0);
		send_op(fpalu_pkg::OP_EQ, 32'h5, 32'h5);
		idle_input();
	endtask

	// Random operations with random operands.
	task automatic test_random(int count);
		for (int i = 0; i < count; i++) begin
			send_op(fpalu_pkg::op_t'($urandom_range(0, 15)), pick_operand(), pick_operand());
		end
		idle_input();
	endtask

	// Pauses the sender until the pipeline has drained completely, then sends 60 random operations.
	task automatic test_drain_pause();
		while (pending_results.size() != 0) @(posedge clk);
		test_random(60);
	endtask

	// Checks each result transfer against the oldest prediction.
	always @(posedge clk) begin
		alu_res_t exp_res;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
			end else begin
				exp_res = pending_results.pop_front();
				if (m_axis_tdata !== exp_res.value || m_axis_tuser[0] !== exp_res.cmp ||
						m_axis_tuser[1] !== exp_res.dz) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h cmp %b dz %b, got %h cmp %b dz %b",
							exp_res.value, exp_res.cmp, exp_res.dz,
							m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]);
				end
			end
		end
	end

	// Receiver stall pattern: long free-running stretches and bursts of back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (cycles % 512 < 128) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	// Cycle counter and timeout.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("FAIL fixed_point_alu");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		burst_left    = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(250);
		test_drain_pause();
		test_random(240);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS fixed_point_alu");
		end else begin
			$display("FAIL fixed_point_alu");
		end
		$finish;
	end
endmodule
